[sv/rans32_pkg.sv]
// shared types and constants of the interleaved rans decoder
// no dependencies; used by rans32_ctrl, rans32_dp and the top level
package rans32_pkg;

    // item kinds carried on s_axis_tuser
    localparam logic [2:0] FUNC_TABLE_WR = 3'd0;
    localparam logic [2:0] FUNC_LANE_INIT = 3'd1;
    localparam logic [2:0] FUNC_ROUND = 3'd2;
    localparam logic [2:0] FUNC_FWD_WORD = 3'd3;
    localparam logic [2:0] FUNC_REV_WORD = 3'd4;

    // lane count and table size are fixed by the item and result layouts
    localparam int LANES = 32;
    localparam int TABLE_BITS = 12;

    localparam int STATE_W = 32;
    localparam int COUNT_W = 5;
    localparam int SYM_MSB = 31;
    localparam int SYM_LSB = 24;
    localparam int IN_DATA_W = 104;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 24;

    // one input request, unpacked
    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] table_index;
        logic [31:0] table_word;
        logic [4:0]  lane;
        logic [31:0] lane_state;
        logic [15:0] stream_word;
    } item_t;

    // one result request
    typedef struct packed {
        logic [7:0]         symbol;
        logic [4:0]         symbol_lane;
        logic               last;
        logic [COUNT_W-1:0] forward_words_needed;
        logic [COUNT_W-1:0] reverse_words_needed;
        logic               finished;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic cfg_we;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic startable;
        logic can_issue;
        logic issue_last;
        logic b_busy;
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } ctrl_state_t;

endpackage

[sv/rans32_ctrl.sv]
// sequencer of the rans decoder: accepts requests and steps a decode round
// depends on rans32_pkg
module rans32_ctrl
    import rans32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  in_func,
    input  logic        cfg_valid,
    input  status_t     status,
    output logic        in_ready,
    output logic        cfg_ready,
    output cmd_t        cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // handshakes are taken only between rounds
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.accept = in_valid && (state_reg == S_IDLE);
        cmd.start = cmd.accept && (in_func == FUNC_ROUND) && status.startable;
        cmd.issue = (state_reg == S_RUN) && status.can_issue;
        cmd.cfg_we = cfg_valid && (state_reg == S_IDLE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cmd.issue && status.issue_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!status.b_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/rans32_dp.sv]
// datapath of the rans decoder: lane states, decode table, lane step, result register
// depends on rans32_pkg; driven by rans32_ctrl
module rans32_dp
    import rans32_pkg::*;
#(
    parameter int RENORM_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  item_t       item,
    input  logic [31:0] cfg_data,
    input  logic        out_ready,
    output status_t     status,
    output logic        out_valid,
    output result_t     out_result
);

    localparam int LW = $clog2(LANES);
    localparam int HALF = LANES / 2;
    localparam int TAB_DEPTH = 2 ** TABLE_BITS;

    // architectural state
    logic [STATE_W-1:0] lane_states_reg [LANES];
    logic [LANES-1:0]   pending_reg;
    logic [31:0]        done_reg;
    logic [31:0]        count_reg;
    logic [STATE_W-1:0] table_mem [TAB_DEPTH];

    // round pipeline
    logic [LW-1:0]      lane_cnt_reg;
    logic               b_valid_reg;
    logic [LW-1:0]      b_lane_reg;
    logic [STATE_W-1:0] b_state_reg;
    logic [STATE_W-1:0] tbl_rdata_reg;
    logic [LANES-1:0]   acc_reg;
    logic [LANES-1:0]   acc_next;
    logic [COUNT_W-1:0] cnt_lo_reg;
    logic [COUNT_W-1:0] cnt_hi_reg;

    // result register
    logic               out_valid_reg;
    result_t            out_reg;

    logic               table_we;
    logic               init_we;
    logic               feed_we;
    logic               init_in_range;
    logic [LW-1:0]      init_idx;
    logic               fwd_found;
    logic               rev_found;
    logic [LW-1:0]      fwd_idx;
    logic [LW-1:0]      rev_idx;
    logic [LW-1:0]      feed_idx;
    logic [LW-1:0]      rd_idx;
    logic [STATE_W-1:0] state_rd;
    logic [STATE_W-1:0] fed_state;

    logic [TABLE_BITS-1:0] freq;
    logic [TABLE_BITS-1:0] bias;
    logic [STATE_W-1:0]    mul_full;
    logic [STATE_W-1:0]    new_state;
    logic                  low_flag;
    logic                  emit;
    logic                  slot_free;
    logic                  b_adv;
    logic [31:0]           done_inc;
    logic [31:0]           done_after;
    logic                  fin;
    logic                  is_last_lane;
    logic                  res_last;
    logic                  commit;

    // item decode
    assign table_we = cmd.accept && (item.func == FUNC_TABLE_WR);
    assign init_in_range = (32'(item.lane) < LANES);
    assign init_we = cmd.accept && (item.func == FUNC_LANE_INIT) && init_in_range;
    assign init_idx = LW'(item.lane);

    // first pending lane on each side
    always_comb
    begin
        fwd_found = 1'b0;
        fwd_idx = '0;
        for (int i = 0; i < HALF; i++)
        begin
            if (!fwd_found && pending_reg[i])
            begin
                fwd_found = 1'b1;
                fwd_idx = LW'(i);
            end
        end
        rev_found = 1'b0;
        rev_idx = '0;
        for (int i = HALF; i < LANES; i++)
        begin
            if (!rev_found && pending_reg[i])
            begin
                rev_found = 1'b1;
                rev_idx = LW'(i);
            end
        end
    end

    always_comb
    begin
        feed_we = 1'b0;
        feed_idx = fwd_idx;
        if (cmd.accept && (item.func == FUNC_FWD_WORD))
        begin
            feed_we = fwd_found;
            feed_idx = fwd_idx;
        end
        else if (cmd.accept && (item.func == FUNC_REV_WORD))
        begin
            feed_we = rev_found;
            feed_idx = rev_idx;
        end
    end

    // single read port on the lane states
    assign rd_idx = feed_we ? feed_idx : lane_cnt_reg;
    assign state_rd = lane_states_reg[rd_idx];
    assign fed_state = (state_rd << RENORM_BITS) | STATE_W'(item.stream_word[RENORM_BITS-1:0]);

    // lane step: freq * (state >> table_bits) + bias
    assign freq = tbl_rdata_reg[TABLE_BITS-1:0];
    assign bias = tbl_rdata_reg[2*TABLE_BITS-1:TABLE_BITS];
    assign mul_full = STATE_W'(freq) * (b_state_reg >> TABLE_BITS);
    assign new_state = mul_full + STATE_W'(bias);
    assign low_flag = (new_state[STATE_W-1:RENORM_BITS] == '0);

    // emit and advance decision
    assign emit = (done_reg < count_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign b_adv = b_valid_reg && (!emit || slot_free);
    assign done_inc = done_reg + 32'd1;
    assign done_after = emit ? done_inc : done_reg;
    assign fin = emit && (done_inc == count_reg);
    assign is_last_lane = (b_lane_reg == LW'(LANES - 1));
    assign res_last = fin || is_last_lane;
    assign commit = b_adv && is_last_lane && (done_after < count_reg);

    always_comb
    begin
        acc_next = acc_reg;
        acc_next[b_lane_reg] = low_flag;
    end

    // status toward the controller
    always_comb
    begin
        status.startable = (done_reg < count_reg) && (pending_reg == '0);
        status.can_issue = !b_valid_reg || b_adv;
        status.issue_last = (lane_cnt_reg == LW'(LANES - 1));
        status.b_busy = b_valid_reg;
    end

    // decode table: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (table_we)
            table_mem[item.table_index[TABLE_BITS-1:0]] <= item.table_word;
        if (cmd.issue)
            tbl_rdata_reg <= table_mem[state_rd[TABLE_BITS-1:0]];
    end

    // lane state array, one write per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
                lane_states_reg[i] <= '0;
        end
        else if (b_adv)
            lane_states_reg[b_lane_reg] <= new_state;
        else if (init_we)
            lane_states_reg[init_idx] <= item.lane_state;
        else if (feed_we)
            lane_states_reg[feed_idx] <= fed_state;
    end

    // pending renorm bits, symbol counters and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            done_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                count_reg <= cfg_data;
                done_reg <= '0;
                pending_reg <= '0;
            end
            else
            begin
                if (b_adv && emit)
                    done_reg <= done_inc;
                if (commit)
                    pending_reg <= acc_next;
                else if (init_we)
                    pending_reg[init_idx] <= 1'b0;
                else if (feed_we)
                    pending_reg[feed_idx] <= 1'b0;
            end
        end
    end

    // lane issue stage and table read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_cnt_reg <= '0;
            b_valid_reg <= 1'b0;
            b_lane_reg <= '0;
            acc_reg <= '0;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                lane_cnt_reg <= '0;
                acc_reg <= '0;
                cnt_lo_reg <= '0;
                cnt_hi_reg <= '0;
            end
            else if (cmd.issue)
                lane_cnt_reg <= lane_cnt_reg + LW'(1);

            if (cmd.issue)
            begin
                b_valid_reg <= 1'b1;
                b_lane_reg <= lane_cnt_reg;
            end
            else if (b_adv)
                b_valid_reg <= 1'b0;

            if (b_adv)
            begin
                acc_reg <= acc_next;
                if (32'(b_lane_reg) < HALF)
                    cnt_lo_reg <= cnt_lo_reg + COUNT_W'(low_flag);
                else
                    cnt_hi_reg <= cnt_hi_reg + COUNT_W'(low_flag);
            end
        end
    end

    // captured lane state for the step stage
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            b_state_reg <= state_rd;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_adv && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && emit)
        begin
            out_reg.symbol <= tbl_rdata_reg[SYM_MSB:SYM_LSB];
            out_reg.symbol_lane <= 5'(b_lane_reg);
            out_reg.last <= res_last;
            out_reg.finished <= fin;
            if (res_last && !fin)
            begin
                out_reg.forward_words_needed <= cnt_lo_reg;
                out_reg.reverse_words_needed <= cnt_hi_reg + COUNT_W'(low_flag);
            end
            else
            begin
                out_reg.forward_words_needed <= '0;
                out_reg.reverse_words_needed <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

endmodule

[sv/rans32_interleaved_decoder.sv]
// top level of the 32-lane interleaved rans decoder
// depends on rans32_pkg, rans32_ctrl and rans32_dp
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser func, tdata table/lane/stream fields
// m_axis    out  m_axis_tvalid/tready      tdata symbol fields, tlast, tuser finished
// cfg       in   cfg_valid/cfg_ready       cfg_data symbol_count
//
// table writes, state inits, stream words and dropped rounds are taken in idle, which stays ready
// for the next request; a decode round keeps the controller busy until it is back in idle:
// one lane per cycle through the single read port of the decode table, then the
// step stage and the return to idle; its last symbol is registered from the step stage
// a stalled m_axis holds the step stage; the lane sequence resumes when it drains
// reset clears lane states, pending bits and counters; the table is not cleared
module rans32_interleaved_decoder
    import rans32_pkg::*;
#(
    parameter int RENORM_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // table_index, table_word, lane, lane_state, stream_word, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // symbol, symbol_lane, forward_words_needed, reverse_words_needed, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    // finished
    output logic [0:0]            m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);

    item_t   item;
    cmd_t    cmd;
    status_t status;
    result_t result;

    // unpack the input request
    always_comb
    begin
        item.func = s_axis_tuser;
        item.table_index = s_axis_tdata[11:0];
        item.table_word = s_axis_tdata[43:12];
        item.lane = s_axis_tdata[48:44];
        item.lane_state = s_axis_tdata[80:49];
        item.stream_word = s_axis_tdata[96:81];
    end

    rans32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (item.func),
        .cfg_valid (cfg_valid),
        .status    (status),
        .in_ready  (s_axis_tready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    rans32_dp #(
        .RENORM_BITS (RENORM_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_result (result)
    );

    // pack the result request
    assign m_axis_tdata = {1'b0, result.reverse_words_needed, result.forward_words_needed,
                           result.symbol_lane, result.symbol};
    assign m_axis_tlast = result.last;
    assign m_axis_tuser = result.finished;

endmodule

[verif/rans32_interleaved_decoder_test.sv]
// self-checking testbench for the 32-lane interleaved rans decoder
// depends on rans32_pkg and rans32_interleaved_decoder; random stimulus with an in-bench
// decoder model, a stream driver and a symbol monitor, plus symbol_count rewrites per phase
module rans32_interleaved_decoder_test
    import rans32_pkg::*;
();

    localparam int LANE_COUNT = 32;
    localparam int HALF_LANES = LANE_COUNT / 2;
    localparam int TAB_BITS = 12;
    localparam int TAB_DEPTH = 1 << TAB_BITS;
    localparam logic [31:0] RENORM_LIMIT = 32'h0001_0000;
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int DRAIN_GAP = 48;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER = 100;
    localparam int PRINT_CAP = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data = '0;

    // decoder model state
    bit [31:0] lane_st [LANE_COUNT];
    bit [31:0] dec_tab [TAB_DEPTH];
    bit        tab_ok [TAB_DEPTH];
    bit [31:0] sym_done;
    bit [31:0] sym_target;
    bit [31:0] owe;
    bit        took;

    // request queue and expected symbols
    item_t   req_q [$];
    result_t sym_due [$];
    item_t   nxt;
    result_t got;
    result_t want;

    bit in_took;
    int send_gap;
    int hold_left;
    bit held_long;
    bit steady;
    int quiet;

    int errors;
    int live_items;
    int ignored_items;
    int results_seen;
    int rounds_run;
    int words_fed;
    int cfg_writes;

    rans32_interleaved_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        if (errors < PRINT_CAP)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, seen, wanted);
        errors++;
    endtask

    // hand a renorm word to the first pending lane of one half
    task automatic take_word(input int base, input logic [15:0] word);
        bit found;
        found = 1'b0;
        for (int i = base; i < base + HALF_LANES; i++)
        begin
            if (!found && owe[i])
            begin
                lane_st[i] = {lane_st[i][15:0], word};
                owe[i] = 1'b0;
                found = 1'b1;
            end
        end
        if (found)
        begin
            took = 1'b1;
            words_fed++;
        end
    endtask

    // one decode round over all lanes
    task automatic decode_round();
        logic [31:0] s;
        logic [31:0] w;
        logic [31:0] freq;
        logic [31:0] hi;
        logic [31:0] bias;
        result_t r;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            s = lane_st[i];
            w = dec_tab[s[TAB_BITS-1:0]];
            freq = {20'd0, w[TAB_BITS-1:0]};
            bias = {20'd0, w[2*TAB_BITS-1:TAB_BITS]};
            hi = {12'd0, s[31:TAB_BITS]};
            lane_st[i] = freq * hi + bias;
            if (sym_done < sym_target)
            begin
                sym_done++;
                r.symbol = w[SYM_MSB:SYM_LSB];
                r.symbol_lane = 5'(i);
                r.last = 1'b0;
                r.forward_words_needed = '0;
                r.reverse_words_needed = '0;
                r.finished = (sym_done == sym_target);
                sym_due.push_back(r);
            end
        end
        // lanes that ran low owe a word unless the count is reached
        if (sym_done < sym_target)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
                if (lane_st[i] < RENORM_LIMIT)
                    owe[i] = 1'b1;
        end
        r = sym_due.pop_back();
        r.last = 1'b1;
        r.forward_words_needed = COUNT_W'($countones(owe[HALF_LANES-1:0]));
        r.reverse_words_needed = COUNT_W'($countones(owe[LANE_COUNT-1:HALF_LANES]));
        sym_due.push_back(r);
        rounds_run++;
    endtask

    // expected effect of one request on the model
    task automatic predict_request(input item_t it);
        took = 1'b0;
        case (it.func)
            FUNC_TABLE_WR:
            begin
                dec_tab[it.table_index] = it.table_word;
                tab_ok[it.table_index] = 1'b1;
                took = 1'b1;
            end
            FUNC_LANE_INIT:
            begin
                lane_st[it.lane] = it.lane_state;
                owe[it.lane] = 1'b0;
                took = 1'b1;
            end
            FUNC_FWD_WORD: take_word(0, it.stream_word);
            FUNC_REV_WORD: take_word(HALF_LANES, it.stream_word);
            FUNC_ROUND:
            begin
                if (sym_done < sym_target && owe == '0)
                begin
                    decode_round();
                    took = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic item_t scrambled();
        item_t it;
        it.func = 3'($urandom);
        it.table_index = 12'($urandom);
        it.table_word = $urandom;
        it.lane = 5'($urandom);
        it.lane_state = $urandom;
        it.stream_word = 16'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] pick_entry();
        case ($urandom_range(0, 7))
            0: return {8'($urandom), 12'($urandom), 12'($urandom_range(0, 15))};
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_state();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_request(input item_t it);
        predict_request(it);
        req_q.push_back(it);
        if (took)
            live_items++;
        else
            ignored_items++;
    endtask

    task automatic put_table(input logic [11:0] idx, input logic [31:0] word);
        item_t it;
        it = scrambled();
        it.func = FUNC_TABLE_WR;
        it.table_index = idx;
        it.table_word = word;
        queue_request(it);
    endtask

    task automatic put_init(input logic [4:0] ln, input logic [31:0] st);
        item_t it;
        it = scrambled();
        it.func = FUNC_LANE_INIT;
        it.lane = ln;
        it.lane_state = st;
        queue_request(it);
    endtask

    task automatic put_word(input logic [2:0] code, input logic [15:0] word);
        item_t it;
        it = scrambled();
        it.func = code;
        it.stream_word = word;
        queue_request(it);
    endtask

    task automatic put_spare();
        item_t it;
        it = scrambled();
        it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        queue_request(it);
    endtask

    // a round that will run must only look up table slots already written
    task automatic put_round();
        item_t it;
        if (sym_done < sym_target && owe == '0)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
                if (!tab_ok[lane_st[i][TAB_BITS-1:0]])
                    put_table(lane_st[i][TAB_BITS-1:0], pick_entry());
        end
        it = scrambled();
        it.func = FUNC_ROUND;
        queue_request(it);
    endtask

    task automatic put_owed_word();
        bit fwd;
        if (owe[HALF_LANES-1:0] != '0 && owe[LANE_COUNT-1:HALF_LANES] != '0)
            fwd = $urandom_range(0, 1);
        else
            fwd = (owe[HALF_LANES-1:0] != '0);
        put_word(fwd ? FUNC_FWD_WORD : FUNC_REV_WORD, pick_word());
    endtask

    // sender holds back until every request is in and every symbol is out
    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || sym_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_count(input logic [31:0] value);
        settle();
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        sym_target = value;
        sym_done = '0;
        owe = '0;
        cfg_writes++;
    endtask

    // mostly well-formed rounds with their owed words, the rest noise
    task automatic run_phase(input logic [31:0] value, input int quota);
        int stop_at;
        int pick;
        int n;
        logic [4:0] ln;
        write_count(value);
        stop_at = live_items + quota;
        while (live_items < stop_at && !(sym_target != 0 && sym_done >= sym_target))
        begin
            pick = $urandom_range(0, 19);
            if (owe != '0)
            begin
                if (pick == 0)
                    put_round();
                else if (pick == 1)
                begin
                    do
                        ln = 5'($urandom);
                    while (!owe[ln]);
                    put_init(ln, pick_state());
                end
                else
                    put_owed_word();
            end
            else if (pick <= 10)
                put_round();
            else if (pick <= 13)
            begin
                n = $urandom_range(1, 3);
                repeat (n) put_init(5'($urandom), pick_state());
            end
            else if (pick <= 16)
                put_table(12'($urandom), pick_entry());
            else if (pick == 17)
                put_spare();
            else if (pick == 18)
                put_word($urandom_range(0, 1) ? FUNC_FWD_WORD : FUNC_REV_WORD, pick_word());
            else if (held_long)
                drain();
        end
    endtask

    // request driver
    always @(posedge clk)
        in_took <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                nxt = req_q.pop_front();
                s_axis_tuser <= nxt.func;
                s_axis_tdata <= {7'd0, nxt.stream_word, nxt.lane_state, nxt.lane,
                                 nxt.table_word, nxt.table_index};
                s_axis_tvalid <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 5);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result ready with short stalls and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!held_long && results_seen >= HOLD_AFTER)
            begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // symbol monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got.symbol = m_axis_tdata[7:0];
            got.symbol_lane = m_axis_tdata[12:8];
            got.forward_words_needed = m_axis_tdata[17:13];
            got.reverse_words_needed = m_axis_tdata[22:18];
            got.last = m_axis_tlast;
            got.finished = m_axis_tuser[0];
            if (sym_due.size() == 0)
                report_mismatch("symbol with nothing due", 32'(got.symbol), '0);
            else
            begin
                want = sym_due.pop_front();
                if (got.symbol != want.symbol)
                    report_mismatch("symbol", 32'(got.symbol), 32'(want.symbol));
                if (got.symbol_lane != want.symbol_lane)
                    report_mismatch("symbol_lane", 32'(got.symbol_lane),
                                    32'(want.symbol_lane));
                if (got.last != want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
                if (got.forward_words_needed != want.forward_words_needed)
                    report_mismatch("forward_words_needed", 32'(got.forward_words_needed),
                                    32'(want.forward_words_needed));
                if (got.reverse_words_needed != want.reverse_words_needed)
                    report_mismatch("reverse_words_needed", 32'(got.reverse_words_needed),
                                    32'(want.reverse_words_needed));
                if (got.finished != want.finished)
                    report_mismatch("finished", 32'(got.finished), 32'(want.finished));
            end
        end
    end

    // watchdog on cycles with no request moving anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("rans32_interleaved_decoder regression: fail");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count still zero after reset: everything here is dropped but the table write
        put_table(12'h000, 32'hFFFF_FFFF);
        put_round();
        put_spare();
        put_word(FUNC_FWD_WORD, 16'hFFFF);
        put_word(FUNC_REV_WORD, 16'h0000);

        // one full round that lands exactly on the count, then a round past the end
        write_count(32'd32);
        put_table(12'hFFF, 32'h0000_0000);
        put_init(5'd0, 32'hFFFF_FFFF);
        put_init(5'd31, 32'h0000_0000);
        put_init(5'd16, 32'h8000_1000);
        put_round();
        put_round();

        run_phase(32'd1, 30);
        run_phase(32'hFFFF_FFFF, 150);
        run_phase(32'd100, 80);
        run_phase(32'd0, 10);
        steady = 1'b1;
        run_phase(32'd3000, 70);

        settle();
        $display("covered %0d requests (%0d dropped by the decoder), %0d decode rounds",
                 live_items + ignored_items, ignored_items, rounds_run);
        $display("checked %0d symbols, fed %0d renorm words, %0d symbol_count writes",
                 results_seen, words_fed, cfg_writes);
        if (errors == 0)
            $display("rans32_interleaved_decoder regression: pass");
        else
            $display("rans32_interleaved_decoder regression: fail");
        $finish;
    end

endmodule

[rans32_interleaved_decoder.f]
sv/rans32_pkg.sv
sv/rans32_ctrl.sv
sv/rans32_dp.sv
sv/rans32_interleaved_decoder.sv
verif/rans32_interleaved_decoder_test.sv
